>>> design/multi_channel_relay_timeout_timer_macros.svh
// Assertion macros for the relay timeout timer.
`ifndef MULTI_CHANNEL_RELAY_TIMEOUT_TIMER_MACROS_SVH
`define MULTI_CHANNEL_RELAY_TIMEOUT_TIMER_MACROS_SVH

// Same-cycle implication.
`define MCRTT_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mcrtt assertion failed");

// Next-cycle implication.
`define MCRTT_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mcrtt assertion failed");

`endif

>>> design/mcrtt_pkg.sv
// Package with types, codes and defaults for the relay timeout timer.
package mcrtt_pkg;

   localparam int CHANNELS_DEF = 4;
   localparam int CHANNELS_MAX = 8;

   localparam int OPCODE_W  = 2;
   localparam int CHANNEL_W = 3;
   localparam int REQ_DUR_W = 24;
   localparam int TIME_W    = 32;
   localparam int MASK_W    = 4;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [OPCODE_W-1:0] OP_TICK     = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ON       = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_OFF      = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_ALL_STOP = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_CHAN = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_CAPPED   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_ON      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_LITERAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_QUARTER     = 2'd2;

   localparam logic [TIME_W-1:0] ONE_HOUR_MS     = 32'd3600000;
   localparam logic [TIME_W-1:0] MAX_ON_RST      = ONE_HOUR_MS;
   localparam logic [TIME_W-1:0] MIN_LITERAL_RST = ONE_HOUR_MS / 12;
   localparam logic [TIME_W-1:0] QUARTER_RST     = ONE_HOUR_MS / 4;

   localparam logic [TIME_W-1:0] CODE_Q1_MIN  = 32'd15;
   localparam logic [TIME_W-1:0] CODE_Q2_MIN  = 32'd30;
   localparam logic [TIME_W-1:0] CODE_Q3_MIN  = 32'd45;
   localparam logic [TIME_W-1:0] CODE_FULL_MIN = 32'd60;
   localparam logic [TIME_W-1:0] CODE_Q1  = 32'd1;
   localparam logic [TIME_W-1:0] CODE_Q2  = 32'd2;
   localparam logic [TIME_W-1:0] CODE_Q3  = 32'd3;
   localparam logic [TIME_W-1:0] CODE_FULL = 32'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_ON_CAP,
      ST_ON_SEL,
      ST_ON_WR,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0] duration;
      logic [TIME_W-1:0] start;
   } entry_type;

endpackage

>>> design/multi_channel_relay_timeout_timer.sv
// Relay timeout timer: per-channel on-timers kept in one entry memory.
//
// channel | ports                               | word
// req     | req_valid/req_stall                 | opcode, channel, duration, time
// rsp     | rsp_valid/rsp_stall                 | relay mask, status
// csr     | csr_wr_en/csr_index/csr_wr_data     | 32-bit register write
//
// Tick: one entry compared per cycle through one subtractor.
// On: cap, code decode with quarter product, then saturate and write back.
// Off, all-stop, bad channel: straight to the finish step. Results leave through one output register.
// Reset clears channel on bits at once; entries of channels that are off are read but ignored.
// A full output register holds the block in its last step until rsp_stall drops.
`include "multi_channel_relay_timeout_timer_macros.svh"

module multi_channel_relay_timeout_timer #(
   parameter int CHANNELS = mcrtt_pkg::CHANNELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mcrtt_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic [mcrtt_pkg::CHANNEL_W-1:0]   req_channel,
   input  logic [mcrtt_pkg::REQ_DUR_W-1:0]   req_duration_ms,
   input  logic [mcrtt_pkg::TIME_W-1:0]      req_now_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mcrtt_pkg::MASK_W-1:0]      rsp_relay_mask,
   output logic [mcrtt_pkg::STATUS_W-1:0]    rsp_status,
   input  logic                              csr_wr_en,
   input  logic [mcrtt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mcrtt_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import mcrtt_pkg::*;

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PROD_W = TIME_W + 2;

   state_type state_ff, state_in;

   logic [TIME_W-1:0] max_on_ff, min_lit_ff, quarter_ff;

   logic [OPCODE_W-1:0]  op_ff;
   logic [CHANNEL_W-1:0] ch_ff;
   logic [REQ_DUR_W-1:0] dur_ff;
   logic [TIME_W-1:0]    now_ff;

   logic [TIME_W-1:0] t_ff, t_in;
   logic              capped_ff, capped_in;
   logic              lit_ff, lit_in;
   logic              rej_ff, rej_in;
   logic              full_ff, full_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   logic [CH_W-1:0]     idx_ff, idx_in;
   logic [CHANNELS-1:0] on_ff, on_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]   rsp_mask_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [MASK_W-1:0]   mask_now;

   entry_type       mem [CHANNELS];
   entry_type       rd_data_ff;
   logic [CH_W-1:0] rd_addr;
   logic            wr_en;
   logic [CH_W-1:0] wr_addr;
   entry_type       wr_data;

   logic              req_take;
   logic              rsp_free;
   logic              ch_bad;
   logic              idx_last;
   logic [TIME_W-1:0] elapsed;
   logic [TIME_W-1:0] new_dur;

   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign ch_bad = ({1'b0, req_channel} >= 4'(CHANNELS));
   assign idx_last = (idx_ff == CH_W'(CHANNELS - 1));
   assign elapsed = now_ff - rd_data_ff.start;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_relay_mask = rsp_mask_ff;
   assign rsp_status = rsp_status_ff;

   for (genvar g = 0; g < MASK_W; g++) begin : g_mask
      if (g < CHANNELS) begin : g_on
         assign mask_now[g] = on_ff[g];
      end else begin : g_off
         assign mask_now[g] = 1'b0;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_on_ff  <= MAX_ON_RST;
         min_lit_ff <= MIN_LITERAL_RST;
         quarter_ff <= QUARTER_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_MAX_ON:      max_on_ff  <= csr_wr_data;
            REG_MIN_LITERAL: min_lit_ff <= csr_wr_data;
            REG_QUARTER:     quarter_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_opcode == OP_TICK) begin
                  state_in = ST_TICK;
               end else if (req_opcode == OP_ON && !ch_bad) begin
                  state_in = ST_ON_CAP;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_TICK: begin
            if (idx_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_ON_CAP: state_in = ST_ON_SEL;
         ST_ON_SEL: state_in = ST_ON_WR;
         ST_ON_WR:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      t_in = t_ff;
      capped_in = capped_ff;
      lit_in = lit_ff;
      rej_in = rej_ff;
      full_in = full_ff;
      prod_in = prod_ff;
      idx_in = idx_ff;
      on_in = on_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_addr = '0;
      wr_en = 1'b0;
      wr_addr = ch_ff[CH_W-1:0];
      new_dur = '0;
      wr_data.duration = new_dur;
      wr_data.start = now_ff;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            status_in = STATUS_OK;
            if (req_take) begin
               if (req_opcode == OP_ALL_STOP) begin
                  on_in = '0;
               end else if (req_opcode != OP_TICK && ch_bad) begin
                  status_in = STATUS_BAD_CHAN;
               end else if (req_opcode == OP_OFF) begin
                  on_in[req_channel[CH_W-1:0]] = 1'b0;
               end
            end
         end
         ST_TICK: begin
            rd_addr = idx_last ? '0 : idx_ff + 1'b1;
            idx_in = idx_ff + 1'b1;
            if (on_ff[idx_ff] && elapsed >= rd_data_ff.duration) begin
               on_in[idx_ff] = 1'b0;
            end
         end
         ST_ON_CAP: begin
            capped_in = ({8'd0, dur_ff} > max_on_ff);
            t_in = capped_in ? max_on_ff : {8'd0, dur_ff};
         end
         ST_ON_SEL: begin
            lit_in = (t_ff >= min_lit_ff);
            rej_in = 1'b0;
            full_in = 1'b0;
            prod_in = '0;
            case (t_ff)
               CODE_Q1, CODE_Q1_MIN: prod_in = {2'b00, quarter_ff};
               CODE_Q2, CODE_Q2_MIN: prod_in = {1'b0, quarter_ff, 1'b0};
               CODE_Q3, CODE_Q3_MIN: prod_in = {2'b00, quarter_ff} + {1'b0, quarter_ff, 1'b0};
               CODE_FULL, CODE_FULL_MIN: full_in = 1'b1;
               default: rej_in = !lit_in;
            endcase
         end
         ST_ON_WR: begin
            if (lit_ff) begin
               new_dur = t_ff;
            end else if (full_ff || prod_ff > {2'b00, max_on_ff}) begin
               new_dur = max_on_ff;
            end else begin
               new_dur = prod_ff[TIME_W-1:0];
            end
            wr_data.duration = new_dur;
            status_in = capped_ff ? STATUS_CAPPED : STATUS_OK;
            if (rej_ff) begin
               status_in = STATUS_REJECTED;
            end else if (new_dur == '0) begin
               on_in[ch_ff[CH_W-1:0]] = 1'b0;
            end else begin
               wr_en = 1'b1;
               on_in[ch_ff[CH_W-1:0]] = 1'b1;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         on_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         on_ff <= on_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff <= req_opcode;
         ch_ff <= req_channel;
         dur_ff <= req_duration_ms;
         now_ff <= req_now_ms;
      end
      t_ff <= t_in;
      capped_ff <= capped_in;
      lit_ff <= lit_in;
      rej_ff <= rej_in;
      full_ff <= full_in;
      prod_ff <= prod_in;
      idx_ff <= idx_in;
      status_ff <= status_in;
      if (state_ff == ST_FINISH && rsp_free) begin
         rsp_mask_ff <= mask_now;
         rsp_status_ff <= status_ff;
      end
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   `MCRTT_ASSERT_IMP(a_write_only_on, clock, reset, wr_en, state_ff == ST_ON_WR && op_ff == OP_ON)
   `MCRTT_ASSERT_NXT(a_all_stop_clears, clock, reset, req_take && req_opcode == OP_ALL_STOP, on_ff == '0)
   `MCRTT_ASSERT_NXT(a_tick_never_sets, clock, reset, state_ff == ST_TICK, (on_ff & ~$past(on_ff)) == '0)
   `MCRTT_ASSERT_IMP(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_FINISH)

endmodule
